FILE: src/dfr_pkg.sv
`default_nettype none
package dfr_pkg;

    // Register map, index = paddr / 4
    localparam int unsigned REG_COUNT      = 5;
    localparam int unsigned REG_IDX_W      = 3;
    localparam int unsigned APB_ADDR_W     = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_FLAG    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ADDRESS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONTROL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MASK    = 3'd4;

    // Reset values of the registers
    localparam logic [7:0] FLAG_RESET    = 8'h7E;
    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [7:0] CONTROL_RESET = 8'h00;
    localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
    localparam logic [7:0] MASK_RESET    = 8'h20;

    // Sequence bit inside the control byte
    localparam logic [7:0] SEQ_CONTROL_BIT = 8'h40;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] address_value;
        logic [7:0] control_base;
        logic [7:0] escape_value;
        logic [7:0] unstuff_mask;
    } cfg_t;

    // One classified line byte
    typedef struct packed {
        logic [7:0] line_byte;
        logic [7:0] unstuffed;
        logic       is_flag;
        logic       is_escape;
        logic       is_address;
    } token_t;

endpackage
`default_nettype wire

FILE: src/dfr_cfg_regs.sv
`default_nettype none
module dfr_cfg_regs (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [dfr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output dfr_pkg::cfg_t                    cfg
);
    import dfr_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register; writes past the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value    <= FLAG_RESET;
            cfg_reg.address_value <= ADDRESS_RESET;
            cfg_reg.control_base  <= CONTROL_RESET;
            cfg_reg.escape_value  <= ESCAPE_RESET;
            cfg_reg.unstuff_mask  <= MASK_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FLAG:    cfg_reg.flag_value    <= pwdata[7:0];
                REG_ADDRESS: cfg_reg.address_value <= pwdata[7:0];
                REG_CONTROL: cfg_reg.control_base  <= pwdata[7:0];
                REG_ESCAPE:  cfg_reg.escape_value  <= pwdata[7:0];
                REG_MASK:    cfg_reg.unstuff_mask  <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_FLAG:    prdata = {24'd0, cfg_reg.flag_value};
            REG_ADDRESS: prdata = {24'd0, cfg_reg.address_value};
            REG_CONTROL: prdata = {24'd0, cfg_reg.control_base};
            REG_ESCAPE:  prdata = {24'd0, cfg_reg.escape_value};
            REG_MASK:    prdata = {24'd0, cfg_reg.unstuff_mask};
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/dfr_front.sv
`default_nettype none
module dfr_front (
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,
    input  dfr_pkg::cfg_t       cfg,
    output logic                push,
    output dfr_pkg::token_t     token,
    input  wire                 queue_full
);
    import dfr_pkg::*;

    // Accept whenever the queue has room
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Classify the byte against the static configuration
    always_comb
    begin
        token.line_byte  = s_tdata;
        token.unstuffed  = s_tdata ^ cfg.unstuff_mask;
        token.is_flag    = (s_tdata == cfg.flag_value);
        token.is_escape  = (s_tdata == cfg.escape_value);
        token.is_address = (s_tdata == cfg.address_value);
    end

endmodule
`default_nettype wire

FILE: src/dfr_queue.sv
`default_nettype none
module dfr_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  dfr_pkg::token_t  push_token,
    output logic             full,
    input  wire              pop,
    output logic             not_empty,
    output dfr_pkg::token_t  pop_token
);
    import dfr_pkg::*;

    token_t                 slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_token = slots[rd_ptr_reg];

    // Store pushed tokens
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_token;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/dfr_back.sv
`default_nettype none
module dfr_back (
    input  wire              clk,
    input  wire              rst_n,
    input  dfr_pkg::cfg_t    cfg,
    input  wire              tok_valid,
    input  dfr_pkg::token_t  tok,
    output logic             pop,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser
);
    import dfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HDR_OK,
        PH_DATA,
        PH_ESCAPED
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] check_reg, check_next;
    logic       seq_reg, seq_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_seq_reg, out_seq_next;

    logic [7:0] ctrl_expected;
    logic       emit;
    logic [1:0] emit_kind;
    logic [7:0] emit_byte;

    // Take a token when the output register is free or draining
    assign pop = tok_valid && (!out_valid_reg || m_tready);

    assign ctrl_expected = cfg.control_base | (seq_reg ? SEQ_CONTROL_BIT : 8'h00);

    // Frame parser
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        check_next = check_reg;
        seq_next   = seq_reg;
        emit       = 1'b0;
        emit_kind  = KIND_PAYLOAD;
        emit_byte  = 8'h00;
        case (phase_reg)
            PH_FLAG:
            begin
                if (tok.is_address)
                    phase_next = PH_ADDR;
                else if (!tok.is_flag)
                    phase_next = PH_HUNT;
            end
            PH_ADDR:
            begin
                if (tok.line_byte == ctrl_expected)
                    phase_next = PH_CTRL;
                else
                    phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
            end
            PH_CTRL:
            begin
                if (tok.line_byte == (cfg.address_value ^ ctrl_expected))
                begin
                    phase_next = PH_HDR_OK;
                    check_next = 8'h00;
                end
                else
                begin
                    phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
                end
            end
            PH_HDR_OK:
            begin
                if (tok.is_flag)
                begin
                    phase_next = PH_FLAG;
                end
                else if (tok.is_escape)
                begin
                    phase_next = PH_ESCAPED;
                end
                else
                begin
                    held_next  = tok.line_byte;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                emit = 1'b1;
                if (tok.is_flag)
                begin
                    // Closing flag: held byte is the trailer check
                    phase_next = PH_HUNT;
                    if (held_reg == check_reg)
                    begin
                        emit_kind = KIND_ACCEPT;
                        seq_next  = !seq_reg;
                    end
                    else
                    begin
                        emit_kind = KIND_REJECT;
                    end
                end
                else
                begin
                    emit_byte  = held_reg;
                    check_next = check_reg ^ held_reg;
                    if (tok.is_escape)
                        phase_next = PH_ESCAPED;
                    else
                        held_next = tok.line_byte;
                end
            end
            PH_ESCAPED:
            begin
                if (tok.is_flag)
                begin
                    // Abort sequence
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                    emit_kind  = KIND_REJECT;
                end
                else
                begin
                    held_next  = tok.unstuffed;
                    phase_next = PH_DATA;
                end
            end
            default:
            begin
                phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
            end
        endcase
    end

    // Output register next values
    always_comb
    begin
        out_kind_next = out_kind_reg;
        out_byte_next = out_byte_reg;
        out_seq_next  = out_seq_reg;
        if (pop)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_kind_next = emit_kind;
                out_byte_next = emit_byte;
                out_seq_next  = seq_reg;
            end
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    // Hold parser state and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            held_reg      <= 8'h00;
            check_reg     <= 8'h00;
            seq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_PAYLOAD;
            out_byte_reg  <= 8'h00;
            out_seq_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                check_reg <= check_next;
                seq_reg   <= seq_next;
            end
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_seq_reg   <= out_seq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_seq_reg, out_byte_reg};

endmodule
`default_nettype wire

FILE: src/info_frame_deframer.sv
`default_nettype none
// Channel  | Direction | Signals                      | Contents (low bit up)
// ---------+-----------+------------------------------+-------------------------------------
// s_axis   | in        | s_tvalid s_tready s_tdata[7:0] | line_byte[7:0]
// m_axis   | out       | m_tvalid m_tready m_tdata[15:0] | payload_byte[7:0], frame_sequence[8]
//          |           | m_tuser[1:0]                  | result_kind[1:0]
// apb      | in/out    | psel penable pwrite paddr[4:0] pwdata prdata pready | 5 byte regs
//
// One line byte per cycle while s_tready is high; a byte is classified and written to the
// queue at its transfer edge and, with an empty queue and an output register that is empty
// or being taken, parsed in the next cycle, which loads its result into the output register.
// A two-entry queue separates classifier and parser; the parser drains it whenever the
// output register is empty or being taken. While a result waits on m_axis the parser holds,
// the queue takes up to two more bytes and s_tready drops. Reset (rst_n, asynchronous)
// returns the parser to the flag hunt with sequence bit zero and loads the register defaults.
module info_frame_deframer (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [7:0]                    s_tdata,   // line_byte[7:0]
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [15:0]                   m_tdata,   // payload_byte[7:0], frame_sequence[8]
    output logic [1:0]                    m_tuser,   // result_kind[1:0]
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [dfr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dfr_pkg::*;

    cfg_t   cfg;
    token_t push_token;
    token_t pop_token;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_not_empty;

    dfr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfr_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .push       (push),
        .token      (push_token),
        .queue_full (queue_full)
    );

    dfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .pop_token  (pop_token)
    );

    dfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (queue_not_empty),
        .tok       (pop_token),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: dv/tb_info_frame_deframer.sv
`timescale 1ns / 1ps

module tb_info_frame_deframer;

    import dfr_pkg::*;

    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = 10;

    // Parser phases of the deframer, mirrored here
    typedef enum logic [2:0] {
        LP_HUNT,
        LP_FLAG,
        LP_ADDR,
        LP_CTRL,
        LP_HDR,
        LP_DATA,
        LP_ESC
    } link_phase_t;

    typedef enum logic [2:0] {
        FS_GOOD,
        FS_BAD_CHECK,
        FS_BAD_HEADER,
        FS_ABORT,
        FS_CUT,
        FS_NOISE
    } frame_style_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       seq;
    } result_t;

    typedef struct packed {
        logic [7:0] line;
        logic       pinned;
        logic [1:0] kind;
        logic [7:0] payload;
        logic       seq;
    } directed_row_t;

    // Directed bytes under reset settings; pinned rows carry a hand-written result
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // line noise, low extreme
        '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // line noise, high extreme
        '{8'h7E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // opening flag
        '{8'h7E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // repeated flag
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h7E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // empty frame
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h7D, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // escape as first payload byte
        '{8'h5E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'hFF, 1'b1, KIND_PAYLOAD, 8'h7E, 1'b0},
        '{8'h81, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h7E, 1'b1, KIND_ACCEPT,  8'h00, 1'b0},  // trailer matches
        '{8'h7E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},  // stale sequence bit
        '{8'h7E, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h40, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h43, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h11, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h7D, 1'b0, KIND_PAYLOAD, 8'h00, 1'b0},
        '{8'h7E, 1'b1, KIND_REJECT,  8'h00, 1'b1}   // flag after escape aborts
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // line_byte[7:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;    // payload_byte[7:0], frame_sequence[8]
    logic [1:0]            m_tuser;    // result_kind[1:0]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Register copies used for prediction
    logic [7:0]  cfg_flag;
    logic [7:0]  cfg_address;
    logic [7:0]  cfg_control;
    logic [7:0]  cfg_escape;
    logic [7:0]  cfg_mask;

    // Parser state used for prediction
    link_phase_t link_phase;
    logic [7:0]  held_byte;
    logic [7:0]  check_acc;
    logic        seq_bit;

    result_t     deframed_q[$];

    logic        sender_gaps;
    logic        receiver_stalls;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned settings_used;
    int unsigned n_payload;
    int unsigned n_accept;
    int unsigned n_reject;

    info_frame_deframer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Advance the parser copy by one line byte; return 1 when a result comes out
    function automatic logic deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0] ctrl;
        logic [7:0] outb;
        logic       seq;
        ctrl = cfg_control | (seq_bit ? SEQ_CONTROL_BIT : 8'h00);
        seq  = seq_bit;
        r    = '0;
        r.seq = seq;
        case (link_phase)
            LP_FLAG:
            begin
                if (b == cfg_address)
                    link_phase = LP_ADDR;
                else if (b != cfg_flag)
                    link_phase = LP_HUNT;
                return 1'b0;
            end
            LP_ADDR:
            begin
                if (b == ctrl)
                    link_phase = LP_CTRL;
                else
                    link_phase = (b == cfg_flag) ? LP_FLAG : LP_HUNT;
                return 1'b0;
            end
            LP_CTRL:
            begin
                if (b == (cfg_address ^ ctrl))
                begin
                    link_phase = LP_HDR;
                    check_acc  = 8'h00;
                end
                else
                begin
                    link_phase = (b == cfg_flag) ? LP_FLAG : LP_HUNT;
                end
                return 1'b0;
            end
            LP_HDR:
            begin
                if (b == cfg_flag)
                    link_phase = LP_FLAG;
                else if (b == cfg_escape)
                    link_phase = LP_ESC;
                else
                begin
                    held_byte  = b;
                    link_phase = LP_DATA;
                end
                return 1'b0;
            end
            LP_DATA:
            begin
                if (b == cfg_flag)
                begin
                    link_phase = LP_HUNT;
                    if (held_byte == check_acc)
                    begin
                        seq_bit = ~seq_bit;
                        r.kind  = KIND_ACCEPT;
                    end
                    else
                    begin
                        r.kind = KIND_REJECT;
                    end
                    return 1'b1;
                end
                outb      = held_byte;
                check_acc = check_acc ^ outb;
                if (b == cfg_escape)
                    link_phase = LP_ESC;
                else
                    held_byte = b;
                r.kind    = KIND_PAYLOAD;
                r.payload = outb;
                return 1'b1;
            end
            LP_ESC:
            begin
                if (b == cfg_flag)
                begin
                    link_phase = LP_HUNT;
                    r.kind     = KIND_REJECT;
                    return 1'b1;
                end
                held_byte  = b ^ cfg_mask;
                link_phase = LP_DATA;
                return 1'b0;
            end
            default:
            begin
                link_phase = (b == cfg_flag) ? LP_FLAG : LP_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one line byte, hold until the transfer, then predict
    task automatic send_byte(input logic [7:0] b, input logic pinned = 1'b0,
                             input result_t pinned_res = '0);
        result_t r;
        logic    got;
        if (sender_gaps && ($urandom_range(0, 4) == 0))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        got = deframe_byte(b, r);
        if (pinned)
            deframed_q.push_back(pinned_res);
        else if (got)
            deframed_q.push_back(r);
        bytes_sent++;
    endtask

    // Drop valid and wait for every predicted result plus the pipeline tail
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access cycle of one register write
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FLAG:    cfg_flag    = value;
            REG_ADDRESS: cfg_address = value;
            REG_CONTROL: cfg_control = value;
            REG_ESCAPE:  cfg_escape  = value;
            REG_MASK:    cfg_mask    = value;
            default:     ;
        endcase
    endtask

    task automatic write_config(input logic [7:0] flag, input logic [7:0] addr,
                                input logic [7:0] ctrl, input logic [7:0] esc,
                                input logic [7:0] mask);
        apb_write(REG_FLAG, flag);
        apb_write(REG_ADDRESS, addr);
        apb_write(REG_CONTROL, ctrl);
        apb_write(REG_ESCAPE, esc);
        apb_write(REG_MASK, mask);
        settings_used++;
    endtask

    // Stuff a byte that collides with flag or escape
    function automatic void put_stuffed(ref logic [7:0] q[$], input logic [7:0] b);
        if ((b == cfg_flag) || (b == cfg_escape))
        begin
            q.push_back(cfg_escape);
            q.push_back(b ^ cfg_mask);
        end
        else
        begin
            q.push_back(b);
        end
    endfunction

    // Build one frame, well formed or broken on purpose, and send it
    task automatic send_frame(input frame_style_t style);
        logic [7:0]  line_q[$];
        logic [7:0]  ctrl;
        logic [7:0]  trailer;
        logic [7:0]  d;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        ctrl    = cfg_control | (seq_bit ? SEQ_CONTROL_BIT : 8'h00);
        trailer = 8'h00;
        if (style == FS_NOISE)
        begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
                line_q.push_back(($urandom_range(0, 3) == 0) ? cfg_flag
                                                             : 8'($urandom_range(0, 255)));
        end
        else
        begin
            line_q.push_back(cfg_flag);
            line_q.push_back(cfg_address);
            line_q.push_back(ctrl);
            line_q.push_back(cfg_address ^ ctrl);
            if (style == FS_BAD_HEADER)
            begin
                i = $urandom_range(1, 3);
                line_q[i] = line_q[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            for (i = 0; i < len; i++)
            begin
                // Favor flag and escape values; skip bytes whose stuffed form is a flag
                do
                begin
                    case ($urandom_range(0, 9))
                        0:       d = cfg_flag;
                        1:       d = cfg_escape;
                        default: d = 8'($urandom_range(0, 255));
                    endcase
                end
                while (((d == cfg_flag) || (d == cfg_escape)) && ((d ^ cfg_mask) == cfg_flag));
                put_stuffed(line_q, d);
                trailer = trailer ^ d;
            end
            if (style == FS_BAD_CHECK)
                trailer = trailer ^ (8'h01 << $urandom_range(0, 7));
            if (style == FS_ABORT)
                line_q.push_back(cfg_escape);
            else
                put_stuffed(line_q, trailer);
            line_q.push_back(cfg_flag);
        end
        cut = line_q.size();
        if (style == FS_CUT)
            cut = $urandom_range(1, line_q.size() - 1);
        for (i = 0; i < cut; i++)
            send_byte(line_q[i]);
        frames_sent++;
    endtask

    // Send frames of a random mix until the byte budget is spent
    task automatic run_frames(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        frame_style_t style;
        start = bytes_sent;
        while ((bytes_sent - start) < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                style = FS_GOOD;
            else if (pick < 75)
                style = FS_BAD_CHECK;
            else if (pick < 85)
                style = FS_BAD_HEADER;
            else if (pick < 90)
                style = FS_ABORT;
            else if (pick < 95)
                style = FS_CUT;
            else
                style = FS_NOISE;
            send_frame(style);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
                m_tready <= 1'b1;
            end
            else if (receiver_stalls && ($urandom_range(0, 4) == 0))
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_output
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected result: result_kind %0d payload_byte 0x%02h",
                       m_tuser, m_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (m_tuser != want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[7:0] != want.payload)
                begin
                    $error("payload_byte: expected 0x%02h, actual 0x%02h",
                           want.payload, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[8] != want.seq)
                begin
                    $error("frame_sequence: expected %0d, actual %0d", want.seq, m_tdata[8]);
                    mismatches++;
                end
                case (m_tuser)
                    KIND_PAYLOAD: n_payload++;
                    KIND_ACCEPT:  n_accept++;
                    default:      n_reject++;
                endcase
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'h0;
        cfg_flag      = FLAG_RESET;
        cfg_address   = ADDRESS_RESET;
        cfg_control   = CONTROL_RESET;
        cfg_escape    = ESCAPE_RESET;
        cfg_mask      = MASK_RESET;
        link_phase    = LP_HUNT;
        held_byte     = 8'h00;
        check_acc     = 8'h00;
        seq_bit       = 1'b0;
        sender_gaps   = 1'b1;
        receiver_stalls = 1'b1;
        hold_requests = 0;
        mismatches    = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        settings_used = 1;
        n_payload     = 0;
        n_accept      = 0;
        n_reject      = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table under reset settings
        foreach (DIRECTED_ROWS[k])
            send_byte(DIRECTED_ROWS[k].line, DIRECTED_ROWS[k].pinned,
                      '{DIRECTED_ROWS[k].kind, DIRECTED_ROWS[k].payload,
                        DIRECTED_ROWS[k].seq});

        // Reset settings, with one long receiver hold-off while frames keep coming
        hold_requests = 1;
        run_frames(130);

        // Low flag, high everything else; leave the parser mid-frame over the write
        send_frame(FS_CUT);
        wait_idle();
        write_config(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_frames(120);

        // High flag, zero address, control, escape and mask
        send_frame(FS_CUT);
        wait_idle();
        write_config(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        run_frames(120);

        // Two random settings with distinct flag and escape
        repeat (2)
        begin
            logic [7:0] f;
            logic [7:0] e;
            wait_idle();
            f = 8'($urandom_range(0, 255));
            do e = 8'($urandom_range(0, 255)); while (e == f);
            write_config(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), e,
                         8'($urandom_range(0, 255)));
            run_frames(120);
        end

        // Back to reset values, no idling on either side
        wait_idle();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        write_config(FLAG_RESET, ADDRESS_RESET, CONTROL_RESET, ESCAPE_RESET, MASK_RESET);
        run_frames(120);

        wait_idle();
        $display("Covered %0d line bytes in %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings_used);
        $display("Results: %0d payload bytes, %0d frames accepted, %0d frames rejected",
                 n_payload, n_accept, n_reject);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
